// ----- rtl/core/lrc_pkg.sv -----
`timescale 1ns / 1ps

package lrc_pkg;

  localparam int          CFG_IDX_W      = 2;
  localparam int          IN_DATA_W      = 8;
  localparam int          OUT_DATA_W     = 176;
  localparam int          QUEUE_DEPTH_DEF = 2;

  localparam logic [31:0] MAGIC_RESET    = 32'h4455_5241;
  localparam logic [31:0] MAX_LEN_RESET  = 32'h0400_0000;
  localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
  localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
  localparam logic [31:0] HDR_BYTES      = 32'd16;
  localparam logic [31:0] SUM_BYTES      = 32'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAGIC   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN = 2'd1;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_GOOD    = 2'd1;
  localparam logic [1:0] KIND_STOP    = 2'd2;
  localparam logic [1:0] KIND_END     = 2'd3;

  // stop reasons
  localparam logic [2:0] STOP_NONE      = 3'd0;
  localparam logic [2:0] STOP_SHORT_HDR = 3'd1;
  localparam logic [2:0] STOP_BAD_MAGIC = 3'd2;
  localparam logic [2:0] STOP_BAD_LEN   = 3'd3;
  localparam logic [2:0] STOP_SHORT_BODY = 3'd4;
  localparam logic [2:0] STOP_CRC       = 3'd5;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [63:0] sequence_no;
    logic [31:0] length;
    logic [2:0]  reason;
    logic [63:0] good_bytes;
  } result_t;

  typedef struct packed {
    logic    vld;
    result_t res;
  } q_push_t;

  typedef struct packed {
    logic                 vld;
    logic [CFG_IDX_W-1:0] idx;
    logic [31:0]          data;
  } cfg_wr_t;

  // reflected crc-32, one byte
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// ----- rtl/core/lrc_parser.sv -----
`timescale 1ns / 1ps

module lrc_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  lrc_pkg::cfg_wr_t cfg,
  input  logic             in_fire,
  input  logic [7:0]       in_byte,
  input  logic             in_last,
  output lrc_pkg::q_push_t push
);
  import lrc_pkg::*;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_CHECK   = 2'd2;
  localparam logic [1:0] PH_HALT    = 2'd3;

  logic [31:0] magic_cfg_r, max_len_cfg_r;
  logic [1:0]  phase_r, phase_nxt;
  logic [31:0] cnt_r, cnt_nxt;
  logic [31:0] magic_r, magic_nxt;
  logic [31:0] len_r, len_nxt;
  logic [63:0] seq_r, seq_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] sum_r, sum_nxt;
  logic [63:0] good_r, good_nxt;
  logic [31:0] crc_upd, cnt_inc, sum_shift;

  assign crc_upd   = crc_byte(crc_r, in_byte);
  assign cnt_inc   = cnt_r + 32'd1;
  assign sum_shift = {sum_r[23:0], in_byte};

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    magic_nxt = magic_r;
    len_nxt   = len_r;
    seq_nxt   = seq_r;
    crc_nxt   = crc_r;
    sum_nxt   = sum_r;
    good_nxt  = good_r;
    push      = '0;
    if (in_fire && phase_r != PH_HALT) begin
      if (in_last) begin
        push.vld            = 1'b1;
        push.res.good_bytes = good_r;
        phase_nxt           = PH_HALT;
        if (phase_r == PH_HEADER) begin
          if (cnt_r == 32'd0) begin
            push.res.kind = KIND_END;
          end else begin
            push.res.kind   = KIND_STOP;
            push.res.reason = STOP_SHORT_HDR;
          end
        end else begin
          push.res.kind        = KIND_STOP;
          push.res.reason      = STOP_SHORT_BODY;
          push.res.sequence_no = seq_r;
          push.res.length      = len_r;
        end
      end else begin
        case (phase_r)
          PH_HEADER: begin
            crc_nxt = crc_upd;
            if (cnt_r < 32'd4) begin
              magic_nxt = {magic_r[23:0], in_byte};
            end else if (cnt_r < 32'd8) begin
              len_nxt = {len_r[23:0], in_byte};
            end else begin
              seq_nxt = {seq_r[55:0], in_byte};
            end
            cnt_nxt = cnt_inc;
            // magic and length are complete well before the last header beat
            if (cnt_inc == HDR_BYTES) begin
              cnt_nxt              = '0;
              push.res.sequence_no = seq_nxt;
              push.res.length      = len_r;
              push.res.good_bytes  = good_r;
              push.res.kind        = KIND_STOP;
              if (magic_r != magic_cfg_r) begin
                push.vld        = 1'b1;
                push.res.reason = STOP_BAD_MAGIC;
                phase_nxt       = PH_HALT;
              end else if (len_r > max_len_cfg_r) begin
                push.vld        = 1'b1;
                push.res.reason = STOP_BAD_LEN;
                phase_nxt       = PH_HALT;
              end else begin
                sum_nxt   = '0;
                phase_nxt = (len_r == 32'd0) ? PH_CHECK : PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            crc_nxt = crc_upd;
            cnt_nxt = cnt_inc;
            if (cnt_inc >= len_r) begin
              cnt_nxt   = '0;
              phase_nxt = PH_CHECK;
            end
            push.vld               = 1'b1;
            push.res.kind          = KIND_PAYLOAD;
            push.res.payload_byte  = in_byte;
            push.res.sequence_no   = seq_r;
            push.res.length        = len_r;
          end
          PH_CHECK: begin
            sum_nxt = sum_shift;
            cnt_nxt = cnt_inc;
            if (cnt_inc == SUM_BYTES) begin
              cnt_nxt              = '0;
              push.vld             = 1'b1;
              push.res.sequence_no = seq_r;
              push.res.length      = len_r;
              if (sum_shift != ~crc_r) begin
                push.res.kind       = KIND_STOP;
                push.res.reason     = STOP_CRC;
                push.res.good_bytes = good_r;
                phase_nxt           = PH_HALT;
              end else begin
                push.res.kind = KIND_GOOD;
                good_nxt      = good_r + {32'd0, len_r} + {32'd0, HDR_BYTES + SUM_BYTES};
                crc_nxt       = ALL_ONES;
                phase_nxt     = PH_HEADER;
              end
            end
          end
          default: begin
            phase_nxt = PH_HALT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_cfg_r   <= MAGIC_RESET;
      max_len_cfg_r <= MAX_LEN_RESET;
      phase_r       <= PH_HEADER;
      cnt_r         <= '0;
      magic_r       <= '0;
      len_r         <= '0;
      seq_r         <= '0;
      crc_r         <= ALL_ONES;
      sum_r         <= '0;
      good_r        <= '0;
    end else begin
      if (cfg.vld && cfg.idx == REG_MAGIC) begin
        magic_cfg_r <= cfg.data;
      end
      if (cfg.vld && cfg.idx == REG_MAX_LEN) begin
        max_len_cfg_r <= cfg.data;
      end
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      magic_r <= magic_nxt;
      len_r   <= len_nxt;
      seq_r   <= seq_nxt;
      crc_r   <= crc_nxt;
      sum_r   <= sum_nxt;
      good_r  <= good_nxt;
    end
  end

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HALT |-> !push.vld)
    else $error("result produced after stop");

  a_push_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld |-> in_fire)
    else $error("result without an input beat");

  a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |-> cnt_r < HDR_BYTES)
    else $error("header byte count out of range");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HALT |=> phase_r == PH_HALT)
    else $error("left halted phase without reset");

endmodule

// ----- rtl/core/lrc_queue.sv -----
`timescale 1ns / 1ps

module lrc_queue #(
  parameter int DEPTH = lrc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lrc_pkg::q_push_t push,
  output logic             full,
  output logic             head_vld,
  output lrc_pkg::result_t head,
  input  logic             pop
);
  import lrc_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  result_t         slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_push, do_pop;

  assign full     = (count_r == FULL_CNT);
  assign head_vld = (count_r != '0);
  assign head     = slot_r[rd_ptr_r];
  assign do_push  = push.vld && !full;
  assign do_pop   = pop && head_vld;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push.vld |-> !full)
    else $error("push into full queue");

endmodule

// ----- rtl/core/lrc_emit.sv -----
`timescale 1ns / 1ps

module lrc_emit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               head_vld,
  input  lrc_pkg::result_t                   head,
  output logic                               pop,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lrc_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [1:0]                         out_tuser
);
  import lrc_pkg::*;

  logic                  vld_r;
  logic [OUT_DATA_W-1:0] data_r;
  logic [1:0]            kind_r;
  logic                  load;

  // output register refills whenever it is empty or its beat is taken
  assign load = !vld_r || out_tready;
  assign pop  = load && head_vld;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= head_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_r <= head.kind;
      data_r <= {5'd0, head.good_bytes, head.reason, head.length,
                 head.sequence_no, head.payload_byte};
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tuser  = kind_r;

endmodule

// ----- rtl/core/log_record_checker.sv -----
`timescale 1ns / 1ps

// Checks a byte stream of framed log records (big-endian magic, 32-bit payload
// length, 64-bit sequence, payload, big-endian reflected CRC-32 over header and
// payload). One input beat per cycle is accepted while the queue is not full: the
// header parser and the one-byte CRC update are combinational, and results pass
// through a short queue and an output register: each result is written to a queue
// slot and then loaded into the output register when that register can refill.
// Payload bytes come out tentatively; the last checksum byte gives a record-good or
// mismatch beat. An end-of-log beat gives a clean end or a short-header/short-body
// stop; after any stop every further beat is taken and ignored until reset.
// Registers: 0 record magic, 1 max payload length; write them only while idle.
module log_record_checker #(
  parameter int QUEUE_DEPTH = lrc_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [lrc_pkg::IN_DATA_W-1:0]     in_tdata,   // [7:0] byte_value
  input  logic                              in_tlast,   // end_of_log
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [7:0] payload_byte, [71:8] record_sequence, [103:72] record_length,
  // [106:104] halt_code, [170:107] good_bytes, [175:171] zero
  output logic [lrc_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [1:0]                        out_tuser,  // [1:0] result_kind
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lrc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data
);
  import lrc_pkg::*;

  cfg_wr_t  cfg;
  q_push_t  push;
  result_t  head;
  logic     q_full, head_vld, pop, in_fire;

  assign cfg_ready = 1'b1;
  assign cfg.vld   = cfg_valid;
  assign cfg.idx   = cfg_index;
  assign cfg.data  = cfg_data;

  assign in_tready = !q_full;
  assign in_fire   = in_tvalid && in_tready;

  lrc_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .in_fire (in_fire),
    .in_byte (in_tdata[7:0]),
    .in_last (in_tlast),
    .push    (push)
  );

  lrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (q_full),
    .head_vld (head_vld),
    .head     (head),
    .pop      (pop)
  );

  lrc_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_vld   (head_vld),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
